// ===== rtl/core/dua_pkg.sv =====
// Shared types and constants of the DMX universe pixel assembler.
`timescale 1ns / 1ps
package dua_pkg;

    localparam int NumPixels    = 135;
    localparam int MaxUniverses = 1;
    localparam int AddrW        = (NumPixels > 1) ? $clog2(NumPixels) : 1;

    localparam int UniW     = 15;
    localparam int ColW     = 8;
    localparam int PixW     = 3 * ColW;
    localparam int CntW     = 8;
    localparam int TimeW    = 16;
    localparam int IdxW     = 8;
    localparam int ProdW    = UniW + CntW;
    localparam int PosW     = ProdW + 1;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam logic [UniW-1:0]  StartUniRst  = 15'd0;
    localparam logic [UniW-1:0]  BrightUniRst = 15'd15;
    localparam logic [TimeW-1:0] TimeoutRst   = 16'd5000;
    localparam logic [ColW-1:0]  BrightRst    = 8'd255;
    localparam logic [CntW-1:0]  CntMax       = 8'd255;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_READ  = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_START_UNI  = 2'd0,
        CFG_BRIGHT_UNI = 2'd1,
        CFG_TIMEOUT    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [UniW-1:0] universe;
        logic            carries_pixel;
        logic [ColW-1:0] red;
        logic [ColW-1:0] green;
        logic [ColW-1:0] blue;
        logic            last_of_packet;
        logic [IdxW-1:0] read_index;
    } t_item;

    typedef struct packed {
        logic                we;
        logic [CfgIdxW-1:0]  idx;
        logic [CfgDataW-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic             wr_en;
        logic [AddrW-1:0] wr_addr;
        logic [PixW-1:0]  wr_data;
        logic             rd_en;
        logic             rd_chk;
        logic [AddrW-1:0] rd_addr;
        logic             clear;
    } t_store_cmd;

    typedef struct packed {
        logic            show;
        logic            done;
        logic [ColW-1:0] bright;
    } t_item_ctl;

endpackage

// ===== rtl/core/dua_in_if.sv =====
// Input item channel of the pixel assembler.
`timescale 1ns / 1ps
interface dua_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [dua_pkg::UniW-1:0] universe;
    logic                     carries_pixel;
    logic [dua_pkg::ColW-1:0] red;
    logic [dua_pkg::ColW-1:0] green;
    logic [dua_pkg::ColW-1:0] blue;
    logic                     last_of_packet;
    logic [dua_pkg::IdxW-1:0] read_index;

    modport source (
        output valid, req_type, universe, carries_pixel, red, green, blue,
               last_of_packet, read_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, universe, carries_pixel, red, green, blue,
               last_of_packet, read_index,
        output ready
    );
endinterface

// ===== rtl/core/dua_out_if.sv =====
// Result channel of the pixel assembler.
`timescale 1ns / 1ps
interface dua_out_if;
    logic                     valid;
    logic                     ready;
    logic [dua_pkg::ColW-1:0] read_red;
    logic [dua_pkg::ColW-1:0] read_green;
    logic [dua_pkg::ColW-1:0] read_blue;
    logic [dua_pkg::ColW-1:0] brightness_level;
    logic                     show_request;
    logic                     frame_complete;

    modport source (
        output valid, read_red, read_green, read_blue, brightness_level,
               show_request, frame_complete,
        input  ready
    );
    modport sink (
        input  valid, read_red, read_green, read_blue, brightness_level,
               show_request, frame_complete,
        output ready
    );
endinterface

// ===== rtl/core/dua_cfg_if.sv =====
// Configuration write channel of the pixel assembler.
`timescale 1ns / 1ps
interface dua_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dua_pkg::CfgIdxW-1:0]  index;
    logic [dua_pkg::CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dua_store.sv =====
// Pixel frame store: synchronous memory with per-entry written bits.
`timescale 1ns / 1ps
module dua_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dua_pkg::t_store_cmd        i_cmd,
    output logic [dua_pkg::PixW-1:0]   o_rd_data,
    output logic                       o_rd_hit
);

    logic [dua_pkg::PixW-1:0]      r_mem [dua_pkg::NumPixels];
    logic [dua_pkg::NumPixels-1:0] r_written;
    logic [dua_pkg::PixW-1:0]      r_rd_data;
    logic                          r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_chk) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    // written bits stand in for the blanked contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_written <= '0;
            end else if (i_cmd.wr_en) begin
                r_written[i_cmd.wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_hit <= i_cmd.rd_chk && r_written[i_cmd.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_hit  = r_rd_hit;

    a_clear_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> !i_cmd.wr_en)
        else $error("store clear and write in the same cycle");

    a_clear_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.clear && i_cmd.rd_en) |=> !r_rd_hit)
        else $error("hit reported on a blanking beat");

    a_raw_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cmd.wr_en) && i_cmd.rd_en && i_cmd.rd_chk
         && (i_cmd.rd_addr == $past(i_cmd.wr_addr))) |=> r_rd_hit)
        else $error("read right after write missed the entry");

endmodule

// ===== rtl/core/dua_ctrl.sv =====
// Packet bookkeeping, configuration registers and store command generation.
`timescale 1ns / 1ps
module dua_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  dua_pkg::t_item       i_item,
    input  dua_pkg::t_cfg_wr     i_cfg,
    output dua_pkg::t_store_cmd  o_cmd,
    output dua_pkg::t_item_ctl   o_ctl
);

    logic [dua_pkg::UniW-1:0]      r_start_uni;
    logic [dua_pkg::UniW-1:0]      r_bright_uni;
    logic [dua_pkg::TimeW-1:0]     r_timeout;
    logic [dua_pkg::MaxUniverses-1:0] r_seen, n_seen;
    logic [dua_pkg::CntW-1:0]      r_stride, n_stride;
    logic [dua_pkg::CntW-1:0]      r_cnt, n_cnt;
    logic [dua_pkg::ColW-1:0]      r_bright, n_bright;
    logic [dua_pkg::TimeW-1:0]     r_ms, n_ms;

    logic                          above;
    logic [dua_pkg::UniW-1:0]      offs;
    logic [dua_pkg::ProdW-1:0]     prod;
    logic [dua_pkg::PosW-1:0]      pos;
    dua_pkg::t_store_cmd           cmd;
    dua_pkg::t_item_ctl            ctl;

    assign above = i_item.universe >= r_start_uni;
    assign offs  = above ? (i_item.universe - r_start_uni) : '0;
    assign prod  = offs * r_stride;
    assign pos   = dua_pkg::PosW'(r_cnt) + dua_pkg::PosW'(prod);

    always_comb begin
        n_seen   = r_seen;
        n_stride = r_stride;
        n_cnt    = r_cnt;
        n_bright = r_bright;
        n_ms     = r_ms;
        cmd      = '0;
        ctl      = '0;

        cmd.wr_addr = pos[dua_pkg::AddrW-1:0];
        cmd.wr_data = {i_item.red, i_item.green, i_item.blue};
        cmd.rd_addr = dua_pkg::AddrW'(i_item.read_index);
        cmd.rd_en   = i_acc;

        if (i_acc) begin
            unique case (dua_pkg::t_req'(i_item.req_type))
                dua_pkg::REQ_PIXEL: begin
                    if (i_item.carries_pixel) begin
                        if ((r_cnt == '0) && (i_item.universe == r_bright_uni)) begin
                            n_bright = i_item.red;
                        end
                        if (r_cnt < dua_pkg::CntMax) begin
                            cmd.wr_en = above && (pos < dua_pkg::PosW'(dua_pkg::NumPixels));
                            n_cnt     = r_cnt + 1'b1;
                        end
                    end
                    if (i_item.last_of_packet) begin
                        for (int k = 0; k < dua_pkg::MaxUniverses; k++) begin
                            if (above && (offs == dua_pkg::UniW'(k))) begin
                                n_seen[k] = 1'b1;
                            end
                        end
                        if (&n_seen) begin
                            ctl.done = 1'b1;
                            ctl.show = 1'b1;
                            n_seen   = '0;
                        end
                        if (i_item.universe == r_bright_uni) begin
                            ctl.show = 1'b1;
                        end
                        n_stride = n_cnt;
                        n_cnt    = '0;
                        n_ms     = '0;
                    end
                end
                dua_pkg::REQ_READ: begin
                    cmd.rd_chk = 32'(i_item.read_index) < dua_pkg::NumPixels;
                end
                dua_pkg::REQ_TICK: begin
                    if (r_ms != '1) begin
                        n_ms = r_ms + 1'b1;
                    end
                    if (n_ms >= r_timeout) begin
                        cmd.clear = 1'b1;
                        ctl.show  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        ctl.bright = n_bright;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= '0;
            r_stride <= '0;
            r_cnt    <= '0;
            r_bright <= dua_pkg::BrightRst;
            r_ms     <= '0;
        end else begin
            r_seen   <= n_seen;
            r_stride <= n_stride;
            r_cnt    <= n_cnt;
            r_bright <= n_bright;
            r_ms     <= n_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_uni  <= dua_pkg::StartUniRst;
            r_bright_uni <= dua_pkg::BrightUniRst;
            r_timeout    <= dua_pkg::TimeoutRst;
        end else if (i_cfg.we) begin
            unique case (dua_pkg::t_cfg_idx'(i_cfg.idx))
                dua_pkg::CFG_START_UNI:  r_start_uni  <= i_cfg.data[dua_pkg::UniW-1:0];
                dua_pkg::CFG_BRIGHT_UNI: r_bright_uni <= i_cfg.data[dua_pkg::UniW-1:0];
                dua_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg.data[dua_pkg::TimeW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cmd = cmd;
    assign o_ctl = ctl;

endmodule

// ===== rtl/core/dmx_universe_pixel_assembler.sv =====
// Top level of the DMX universe pixel assembler.
//
//  channel  | dir | handshake      | beat content
//  ---------+-----+----------------+----------------------------------------------
//  i_in     | in  | valid / ready  | request type, universe, pixel, packet end, index
//  o_out    | out | valid / ready  | read pixel, brightness, show request, frame done
//  i_cfg    | in  | valid / ready  | register index, write data (ready always high)
//
// One item per cycle sustained unless o_out stalls; a result passes the read stage and
// then the output register. The frame store memory has a registered read, which sets
// the latency; all state updates of an item land at its input edge, so no interlock is
// needed. Synchronous active-low reset clears all written bits together: no clearing pass.
// A stall on o_out fills the output register and then the read stage, after which
// i_in.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module dmx_universe_pixel_assembler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dua_in_if.sink        i_in,
    dua_out_if.source     o_out,
    dua_cfg_if.sink       i_cfg
);

    dua_pkg::t_item        item;
    dua_pkg::t_cfg_wr      cfg_wr;
    dua_pkg::t_store_cmd   cmd;
    dua_pkg::t_item_ctl    ctl;
    logic [dua_pkg::PixW-1:0] rd_data;
    logic                  rd_hit;

    logic                  in_acc;
    logic                  s1_adv;
    logic                  out_acc;

    logic                  r_s1_vld;
    dua_pkg::t_item_ctl    r_s1_ctl;
    logic                  r_out_vld;
    dua_pkg::t_item_ctl    r_out_ctl;
    logic [dua_pkg::PixW-1:0] r_out_pix;

    // pack the input beat
    assign item.req_type       = i_in.req_type;
    assign item.universe       = i_in.universe;
    assign item.carries_pixel  = i_in.carries_pixel;
    assign item.red            = i_in.red;
    assign item.green          = i_in.green;
    assign item.blue           = i_in.blue;
    assign item.last_of_packet = i_in.last_of_packet;
    assign item.read_index     = i_in.read_index;

    // configuration is always taken
    assign i_cfg.ready = 1'b1;
    assign cfg_wr.we   = i_cfg.valid;
    assign cfg_wr.idx  = i_cfg.index;
    assign cfg_wr.data = i_cfg.data;

    // advance the read stage when the output register is free or draining
    assign out_acc    = r_out_vld && o_out.ready;
    assign s1_adv     = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    dua_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_item  (item),
        .i_cfg   (cfg_wr),
        .o_cmd   (cmd),
        .o_ctl   (ctl)
    );

    dua_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_rd_data (rd_data),
        .o_rd_hit  (rd_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= in_acc || (r_s1_vld && !s1_adv);
            r_out_vld <= s1_adv || (r_out_vld && !out_acc);
        end
    end

    // hold the item's flags while the memory read completes
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctl <= ctl;
        end
        if (s1_adv) begin
            r_out_ctl <= r_s1_ctl;
            r_out_pix <= rd_hit ? rd_data : '0;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.read_red         = r_out_pix[3*dua_pkg::ColW-1:2*dua_pkg::ColW];
    assign o_out.read_green       = r_out_pix[2*dua_pkg::ColW-1:dua_pkg::ColW];
    assign o_out.read_blue        = r_out_pix[dua_pkg::ColW-1:0];
    assign o_out.brightness_level = r_out_ctl.bright;
    assign o_out.show_request     = r_out_ctl.show;
    assign o_out.frame_complete   = r_out_ctl.done;

    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_ctl.done) |-> r_out_ctl.show)
        else $error("frame complete without show request");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !(r_s1_vld && r_out_vld && !o_out.ready))
        else $error("input beat taken while both stages are blocked");

    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_vld)
        else $error("advanced item missing from output register");

endmodule
